### design/assert_macros.svh
// Assertion macros used by the divide-step controller.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

### design/ndiv_pkg.sv
// Shared types and constants for the non-restoring divide-step unit.
// No dependencies; used by ndiv_ctrl, ndiv_dp and the top level.
package ndiv_pkg;

    localparam int ACC_W = 56;
    localparam int DIV_W = 24;
    localparam int CNT_W = 12;
    // Divisor is aligned at accumulator bits 47..24
    localparam int DIV_SHIFT = 24;
    localparam int SIGN_FILL_W = ACC_W - DIV_W - DIV_SHIFT;
    localparam int MSB_POS = ACC_W - 1;

    localparam logic [CNT_W-1:0] MAX_REPEAT = 12'd4095;

    // Controller states, one-hot
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic step;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic load_zero;
        logic cnt_last;
    } t_sts;

endpackage

### design/ndiv_dp.sv
// Datapath: accumulator, flags, step counter and the 56-bit add/subtract step.
// Depends on ndiv_pkg; driven by commands from ndiv_ctrl.
module ndiv_dp (
    input  logic                              i_clk,
    input  ndiv_pkg::t_cmd                    i_cmd,
    output ndiv_pkg::t_sts                    o_sts,
    input  logic [ndiv_pkg::ACC_W-1:0]        i_acc_in,
    input  logic signed [ndiv_pkg::DIV_W-1:0] i_divisor,
    input  logic                              i_carry_in,
    input  logic                              i_sticky_in,
    input  logic [ndiv_pkg::CNT_W-1:0]        i_repeat_count,
    output logic [ndiv_pkg::ACC_W-1:0]        o_acc_out,
    output logic                              o_carry_out,
    output logic                              o_overflow_out,
    output logic                              o_sticky_out
);

    logic [ndiv_pkg::ACC_W-1:0] r_acc, n_acc;
    logic [ndiv_pkg::DIV_W-1:0] r_div, n_div;
    logic                       r_c, n_c;
    logic                       r_v, n_v;
    logic                       r_l, n_l;
    logic [ndiv_pkg::CNT_W-1:0] r_cnt, n_cnt;

    logic                       dsign;
    logic                       sub;
    logic                       step_v;
    logic [ndiv_pkg::ACC_W-1:0] pos;
    logic [ndiv_pkg::ACC_W-1:0] term;
    logic [ndiv_pkg::ACC_W-1:0] shifted;
    logic [ndiv_pkg::ACC_W-1:0] sum;
    logic [ndiv_pkg::CNT_W-1:0] sat_cnt;

    // Form the aligned divisor and one step: 2*acc + C -/+ divisor
    always_comb begin
        dsign   = r_div[ndiv_pkg::DIV_W-1];
        pos     = {{ndiv_pkg::SIGN_FILL_W{dsign}}, r_div, {ndiv_pkg::DIV_SHIFT{1'b0}}};
        sub     = (r_acc[ndiv_pkg::MSB_POS] == dsign);
        term    = sub ? ~pos : pos;
        shifted = {r_acc[ndiv_pkg::MSB_POS-1:0], r_c};
        sum     = shifted + term + {{(ndiv_pkg::ACC_W-1){1'b0}}, sub};
        step_v  = r_acc[ndiv_pkg::MSB_POS] ^ r_acc[ndiv_pkg::MSB_POS-1];
    end

    // Clamp the step count
    assign sat_cnt = (i_repeat_count > ndiv_pkg::MAX_REPEAT) ? ndiv_pkg::MAX_REPEAT
                                                             : i_repeat_count;

    // Load a new item or advance one step
    always_comb begin
        n_acc = r_acc;
        n_div = r_div;
        n_c   = r_c;
        n_v   = r_v;
        n_l   = r_l;
        n_cnt = r_cnt;
        priority if (i_cmd.load) begin
            n_acc = i_acc_in;
            n_div = i_divisor;
            n_c   = i_carry_in;
            n_v   = 1'b0;
            n_l   = i_sticky_in;
            n_cnt = sat_cnt;
        end else if (i_cmd.step) begin
            n_acc = sum;
            n_c   = ~sum[ndiv_pkg::MSB_POS];
            n_v   = step_v;
            n_l   = r_l | step_v;
            n_cnt = r_cnt - {{(ndiv_pkg::CNT_W-1){1'b0}}, 1'b1};
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_div <= n_div;
        r_c   <= n_c;
        r_v   <= n_v;
        r_l   <= n_l;
        r_cnt <= n_cnt;
    end

    // Status back to the controller
    assign o_sts.load_zero = (i_repeat_count == '0);
    assign o_sts.cnt_last  = (r_cnt == {{(ndiv_pkg::CNT_W-1){1'b0}}, 1'b1});

    assign o_acc_out      = r_acc;
    assign o_carry_out    = r_c;
    assign o_overflow_out = r_v;
    assign o_sticky_out   = r_l;

endmodule

### design/ndiv_ctrl.sv
// Controller state machine: sequences load, divide steps and result hand-off.
// Depends on ndiv_pkg and assert_macros.svh; commands ndiv_dp.
`include "assert_macros.svh"

module ndiv_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_out_stall,
    input  ndiv_pkg::t_sts i_sts,
    output ndiv_pkg::t_cmd o_cmd,
    output logic           o_in_stall,
    output logic           o_out_valid
);

    ndiv_pkg::t_state r_state, n_state;
    logic             out_take;
    logic             in_take;

    // Handshakes: take a new item when idle or while the result leaves
    assign o_out_valid = (r_state == ndiv_pkg::S_DONE);
    assign out_take    = o_out_valid && !i_out_stall;
    assign o_in_stall  = !((r_state == ndiv_pkg::S_IDLE) || out_take);
    assign in_take     = i_in_valid && !o_in_stall;

    assign o_cmd.load = in_take;
    assign o_cmd.step = (r_state == ndiv_pkg::S_RUN);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ndiv_pkg::S_IDLE: begin
                if (in_take) begin
                    n_state = i_sts.load_zero ? ndiv_pkg::S_DONE : ndiv_pkg::S_RUN;
                end
            end
            ndiv_pkg::S_RUN: begin
                if (i_sts.cnt_last) begin
                    n_state = ndiv_pkg::S_DONE;
                end
            end
            ndiv_pkg::S_DONE: begin
                if (in_take) begin
                    n_state = i_sts.load_zero ? ndiv_pkg::S_DONE : ndiv_pkg::S_RUN;
                end else if (out_take) begin
                    n_state = ndiv_pkg::S_IDLE;
                end
            end
            default: n_state = ndiv_pkg::S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ndiv_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Checks
    `ASSERT_IMPL(a_run_stalls_input, i_clk, i_rst_n, r_state == ndiv_pkg::S_RUN, o_in_stall)
    `ASSERT_IMPL(a_load_step_excl, i_clk, i_rst_n, o_cmd.step, !o_cmd.load)
    `ASSERT_NEXT(a_last_step_done, i_clk, i_rst_n, o_cmd.step && i_sts.cnt_last, o_out_valid)

endmodule

### design/nonrestoring_divide_steps_unit.sv
// Top level of the non-restoring divide-step unit.
// Depends on ndiv_pkg, ndiv_ctrl and ndiv_dp.
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+------------------------------------------
//  input    | i_in_valid   | o_in_stall   | i_acc_in i_divisor i_carry_in
//           |              |              | i_sticky_in i_repeat_count
//  output   | o_out_valid  | i_out_stall  | o_acc_out o_carry_out o_overflow_out
//           |              |              | o_sticky_out
//
// An item with repeat count N >= 1 has its result valid once N steps have run:
// the accepting edge loads the datapath, then one 56-bit add/subtract
// step runs per cycle. A count of zero goes straight to done with the loaded values.
// A new item is taken in the cycle its predecessor's result leaves, but not
// while steps are running.
// Reset (synchronous, active low) returns the controller to idle.
module nonrestoring_divide_steps_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [ndiv_pkg::ACC_W-1:0]        i_acc_in,
    input  logic signed [ndiv_pkg::DIV_W-1:0] i_divisor,
    input  logic                              i_carry_in,
    input  logic                              i_sticky_in,
    input  logic [ndiv_pkg::CNT_W-1:0]        i_repeat_count,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ndiv_pkg::ACC_W-1:0]        o_acc_out,
    output logic                              o_carry_out,
    output logic                              o_overflow_out,
    output logic                              o_sticky_out
);

    ndiv_pkg::t_cmd cmd;
    ndiv_pkg::t_sts sts;

    // Sequencer
    ndiv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // Accumulator and step logic
    ndiv_dp u_dp (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_acc_in       (i_acc_in),
        .i_divisor      (i_divisor),
        .i_carry_in     (i_carry_in),
        .i_sticky_in    (i_sticky_in),
        .i_repeat_count (i_repeat_count),
        .o_acc_out      (o_acc_out),
        .o_carry_out    (o_carry_out),
        .o_overflow_out (o_overflow_out),
        .o_sticky_out   (o_sticky_out)
    );

endmodule

### tb/tb_nonrestoring_divide_steps_unit.sv
// Self-checking testbench for nonrestoring_divide_steps_unit.
// Depends on ndiv_pkg and the unit itself; predicts each result with its own
// step-by-step division model and checks it against the output channel.
module tb_nonrestoring_divide_steps_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     ACC_W       = ndiv_pkg::ACC_W;
    localparam int     DIV_W       = ndiv_pkg::DIV_W;
    localparam int     CNT_W       = ndiv_pkg::CNT_W;
    localparam int     DIV_SHIFT   = ndiv_pkg::DIV_SHIFT;
    localparam int     SIGN_FILL_W = ndiv_pkg::SIGN_FILL_W;
    localparam int     MSB_POS     = ndiv_pkg::MSB_POS;
    localparam logic [ndiv_pkg::CNT_W-1:0] MAX_REPEAT = ndiv_pkg::MAX_REPEAT;

    localparam int     CLK_HALF        = 10;
    localparam int     RESET_CYCLES    = 11;
    localparam int     ITEMS_PER_PHASE = 420;
    localparam int     HOLD_CYCLES     = 300;
    localparam int     DRAIN_CYCLES    = 20;
    localparam longint CYCLE_LIMIT     = 2_000_000;

    // One division request and the state it leaves behind
    typedef struct {
        logic [ACC_W-1:0]        acc;
        logic signed [DIV_W-1:0] div;
        logic                    carry;
        logic                    sticky;
        logic [CNT_W-1:0]        count;
    } t_dstep_item;

    typedef struct {
        logic [ACC_W-1:0] acc;
        logic             carry;
        logic             overflow;
        logic             sticky;
    } t_dstep_res;

    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_in_valid     = 1'b0;
    logic                    o_in_stall;
    logic [ACC_W-1:0]        i_acc_in       = '0;
    logic signed [DIV_W-1:0] i_divisor      = '0;
    logic                    i_carry_in     = 1'b0;
    logic                    i_sticky_in    = 1'b0;
    logic [CNT_W-1:0]        i_repeat_count = '0;
    logic                    o_out_valid;
    logic                    i_out_stall    = 1'b0;
    logic [ACC_W-1:0]        o_acc_out;
    logic                    o_carry_out;
    logic                    o_overflow_out;
    logic                    o_sticky_out;

    t_dstep_item job_q[$];
    t_dstep_res  division_q[$];

    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    bit     in_taken       = 1'b0;
    bit     hold_req       = 1'b0;
    bit     hold_served    = 1'b0;
    int     hold_left      = 0;
    longint cycle_count    = 0;
    int     fail_count     = 0;
    int     items_accepted = 0;
    int     results_seen   = 0;
    int     zero_step_items = 0;
    int     max_step_items = 0;
    int     overflow_results = 0;

    nonrestoring_divide_steps_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_acc_in       (i_acc_in),
        .i_divisor      (i_divisor),
        .i_carry_in     (i_carry_in),
        .i_sticky_in    (i_sticky_in),
        .i_repeat_count (i_repeat_count),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_acc_out      (o_acc_out),
        .o_carry_out    (o_carry_out),
        .o_overflow_out (o_overflow_out),
        .o_sticky_out   (o_sticky_out)
    );

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Run the requested number of add/subtract steps on a private copy
    function automatic t_dstep_res divide_steps(t_dstep_item req);
        t_dstep_res       res;
        logic [ACC_W-1:0] acc;
        logic [ACC_W-1:0] add_term;
        logic [ACC_W-1:0] sub_term;
        logic             carry;
        logic             ovf;
        logic             sticky;
        int               steps;
        acc      = req.acc;
        carry    = req.carry;
        sticky   = req.sticky;
        ovf      = 1'b0;
        add_term = {{SIGN_FILL_W{req.div[DIV_W-1]}}, req.div, {DIV_SHIFT{1'b0}}};
        sub_term = ~add_term + {{(ACC_W-1){1'b0}}, 1'b1};
        steps    = int'(req.count);
        if (steps > MAX_REPEAT) begin
            steps = int'(MAX_REPEAT);
        end
        for (int i = 0; i < steps; i++) begin
            ovf    = acc[MSB_POS] ^ acc[MSB_POS-1];
            sticky = sticky | ovf;
            acc    = {acc[ACC_W-2:0], carry}
                     + ((acc[MSB_POS] == req.div[DIV_W-1]) ? sub_term : add_term);
            carry  = ~acc[MSB_POS];
        end
        res.acc      = acc;
        res.carry    = carry;
        res.overflow = ovf;
        res.sticky   = sticky;
        return res;
    endfunction

    function automatic logic [ACC_W-1:0] rand_acc();
        return ACC_W'({$urandom, $urandom});
    endfunction

    // Mostly realistic division operands with random content, some raw noise
    function automatic t_dstep_item random_item();
        t_dstep_item             it;
        logic signed [ACC_W-1:0] sx;
        int                      width;
        int                      pick;
        pick = $urandom_range(99);
        if (pick < 5) begin
            it.count = '0;
        end else if (pick < 70) begin
            it.count = CNT_W'($urandom_range(32, 1));
        end else if (pick < 85) begin
            it.count = CNT_W'(24);
        end else if (pick < 96) begin
            it.count = CNT_W'($urandom_range(255, 33));
        end else if (pick < 99) begin
            it.count = CNT_W'($urandom_range(MAX_REPEAT - 1, 256));
        end else begin
            it.count = MAX_REPEAT;
        end
        // sign-extend a random dividend of random width, or take raw bits
        if ($urandom_range(3) == 0) begin
            it.acc = rand_acc();
        end else begin
            width  = $urandom_range(ACC_W - 1, 1);
            sx     = rand_acc() << (ACC_W - width);
            it.acc = sx >>> (ACC_W - width);
        end
        pick = $urandom_range(99);
        if (pick < 10) begin
            case ($urandom_range(4))
                0:       it.div = {1'b1, {(DIV_W-1){1'b0}}};
                1:       it.div = {1'b0, {(DIV_W-1){1'b1}}};
                2:       it.div = '0;
                3:       it.div = DIV_W'(1);
                default: it.div = DIV_W'(-1);
            endcase
        end else if (pick < 30) begin
            it.div = DIV_W'(int'($urandom_range(255)) - 128);
        end else begin
            it.div = DIV_W'($urandom);
        end
        it.carry  = 1'($urandom_range(1));
        it.sticky = 1'($urandom_range(1));
        return it;
    endfunction

    task automatic queue_item(logic [ACC_W-1:0] acc, logic signed [DIV_W-1:0] div,
                              logic carry, logic sticky, logic [CNT_W-1:0] count);
        t_dstep_item it;
        it.acc    = acc;
        it.div    = div;
        it.carry  = carry;
        it.sticky = sticky;
        it.count  = count;
        job_q.push_back(it);
    endtask

    task automatic wait_drained();
        while (job_q.size() != 0 || division_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Drive the input channel: advance on accept, hold while stalled
    always @(negedge i_clk) begin : drive_inputs
        t_dstep_item done;
        if (in_taken) begin
            done = job_q.pop_front();
        end
        if (i_in_valid && !in_taken) begin
            // hold the stalled item
        end else if (job_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            i_in_valid     <= 1'b1;
            i_acc_in       <= job_q[0].acc;
            i_divisor      <= job_q[0].div;
            i_carry_in     <= job_q[0].carry;
            i_sticky_in    <= job_q[0].sticky;
            i_repeat_count <= job_q[0].count;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Drive receiver stall, with one long hold-off once a result is waiting
    always @(negedge i_clk) begin : drive_stall
        if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_req && !hold_served && o_out_valid) begin
            hold_served = 1'b1;
            hold_left   = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Record accepted items, check accepted results, watch the cycle limit
    always @(posedge i_clk) begin : check_outputs
        t_dstep_item got_in;
        t_dstep_res  want;
        cycle_count = cycle_count + 1;
        in_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (in_taken) begin
            got_in.acc    = i_acc_in;
            got_in.div    = i_divisor;
            got_in.carry  = i_carry_in;
            got_in.sticky = i_sticky_in;
            got_in.count  = i_repeat_count;
            division_q.push_back(divide_steps(got_in));
            items_accepted++;
            if (got_in.count == 0) zero_step_items++;
            if (got_in.count == MAX_REPEAT) max_step_items++;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (o_overflow_out) overflow_results++;
            if (division_q.size() == 0) begin
                $display("%0t: unexpected result, acc_out %h", $time, o_acc_out);
                fail_count++;
            end else begin
                want = division_q.pop_front();
                if (o_acc_out !== want.acc) begin
                    $display("%0t: acc_out mismatch, expected %h, got %h",
                             $time, want.acc, o_acc_out);
                    fail_count++;
                end
                if (o_carry_out !== want.carry) begin
                    $display("%0t: carry_out mismatch, expected %b, got %b",
                             $time, want.carry, o_carry_out);
                    fail_count++;
                end
                if (o_overflow_out !== want.overflow) begin
                    $display("%0t: overflow_out mismatch, expected %b, got %b",
                             $time, want.overflow, o_overflow_out);
                    fail_count++;
                end
                if (o_sticky_out !== want.sticky) begin
                    $display("%0t: sticky_out mismatch, expected %b, got %b",
                             $time, want.sticky, o_sticky_out);
                    fail_count++;
                end
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, division_q.size());
            $display("tb_nonrestoring_divide_steps_unit failed");
            $finish;
        end
    end

    initial begin : run_test
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: flag extremes, divisor extremes, zero and maximum counts
        queue_item(56'h00_0000_0000_0000, 24'sd1, 1'b0, 1'b0, 12'd1);
        queue_item(56'hFF_FFFF_FFFF_FFFF, -24'sd1, 1'b1, 1'b0, 12'd1);
        queue_item(56'h80_0000_0000_0000, 24'sh7FFFFF, 1'b0, 1'b0, 12'd1);
        queue_item(56'h40_0000_0000_0000, 24'sh800000, 1'b1, 1'b0, 12'd1);
        queue_item(56'h7F_FFFF_FFFF_FFFF, 24'sh800000, 1'b0, 1'b0, 12'd2);
        queue_item(56'hC0_0000_0000_0000, 24'sh7FFFFF, 1'b1, 1'b1, 12'd3);
        queue_item(56'h12_3456_789A_BCDE, -24'sd5, 1'b1, 1'b1, 12'd0);
        queue_item(56'hFF_FFFF_FFFF_FFFF, 24'sd7, 1'b0, 1'b0, 12'd0);
        queue_item(56'h00_0000_0100_0000, 24'sd0, 1'b0, 1'b0, 12'd24);
        queue_item(56'h00_1000_0000_0000, 24'sh400000, 1'b0, 1'b0, 12'd24);
        queue_item(56'hFF_F000_0000_0000, 24'sh400000, 1'b0, 1'b0, 12'd24);
        queue_item(56'h00_2000_0000_0000, -24'sh400000, 1'b0, 1'b0, 12'd24);
        queue_item(56'h3A_5C0F_1234_9876, 24'sd3, 1'b1, 1'b0, MAX_REPEAT);
        queue_item(56'h00_0000_0000_0000, 24'sh800000, 1'b1, 1'b0, MAX_REPEAT);
        queue_item(56'h55_5555_5555_5555, 24'sh2AAAAA, 1'b0, 1'b1, 12'h800);
        queue_item(56'h00_7FFF_FF00_0000, 24'sh7FFFFF, 1'b1, 1'b0, 12'd23);
        queue_item(56'hFF_8000_0000_0000, 24'sh800000, 1'b0, 1'b0, 12'd25);
        wait_drained();

        // Random phases; each ends by waiting until all items are drained
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_req       = 1'b1;
                end
                1: begin
                    send_idle_pct  = 74;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 74;
                end
                default: begin
                    send_idle_pct  = 8;
                    recv_stall_pct = 8;
                end
            endcase
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                job_q.push_back(random_item());
            end
            wait_drained();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d division items (%0d with no steps, %0d at the full count),",
                 items_accepted, zero_step_items, max_step_items);
        $display("checked %0d results, %0d with overflow set, over four idle mixes.",
                 results_seen, overflow_results);
        if (fail_count == 0 && division_q.size() == 0) begin
            $display("tb_nonrestoring_divide_steps_unit passed");
        end else begin
            $display("tb_nonrestoring_divide_steps_unit failed");
        end
        $finish;
    end

endmodule
